FILE: hw/rtl/dmpb_pkg.sv
// Shared types and constants for the minimum-depth pyramid builder.
`timescale 1ns / 1ps
package dmpb_pkg;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_LEVELS = 12;
    localparam int DEPTH_W = 24;
    localparam int COORD_W = 24;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int ITER_W  = $clog2(ROOT_W);
    localparam int COL_W   = 13;
    localparam int ROW_W   = 12;
    localparam int LVL_W   = 4;
    localparam int Q_DEPTH = 2;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
    localparam logic [12:0] MAX_HEIGHT = 13'd4096;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LEVELS = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } t_in;

    typedef struct packed {
        logic [LVL_W-1:0]   level;
        logic [11:0]        col;
        logic [11:0]        row;
        logic [DEPTH_W-1:0] depth;
        logic               last;
        logic               frame_min_valid;
        logic [DEPTH_W-1:0] frame_min;
    } t_out;

    // Clamped frame geometry shared by the front and back parts.
    typedef struct packed {
        logic [12:0]      w;
        logic [12:0]      h;
        logic [LVL_W-1:0] nl;
    } t_cfg;

    // One level-0 pixel handed from the front to the back.
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               frame_start;
        logic               frame_end;
    } t_q;

    function automatic logic [DEPTH_W-1:0] min24(input logic [DEPTH_W-1:0] a,
                                                 input logic [DEPTH_W-1:0] b);
        return (a < b) ? a : b;
    endfunction
endpackage

FILE: hw/rtl/dmpb_front.sv
// Front part: pixel position counters and the rounded Euclidean length.
`timescale 1ns / 1ps
module dmpb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dmpb_pkg::t_cfg i_cfg,
    input  logic           i_cfg_wr,
    input  logic           i_in_valid,
    input  dmpb_pkg::t_in  i_in_data,
    output logic           o_in_stall,
    output logic           o_push,
    output dmpb_pkg::t_q   o_push_data,
    input  logic           i_full
);
    import dmpb_pkg::*;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_MUL  = 3'd1;
    localparam logic [2:0] F_ADD  = 3'd2;
    localparam logic [2:0] F_ROOT = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [COL_W-1:0]   r_col_cnt;
    logic [ROW_W-1:0]   r_row_cnt;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic               r_start, r_end;
    logic [COORD_W-1:0] r_mx, r_my, r_mz;
    logic [SQ_W-1:0]    r_sx, r_sy, r_sz;
    logic [SUM_W-1:0]   r_rad;
    logic [REM_W-1:0]   r_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [ITER_W-1:0]  r_iter;

    logic               accept;
    logic               col_wrap, row_wrap;
    logic [REM_W+1:0]   rem_sh, trial;
    logic [ROOT_W:0]    rounded;
    logic [DEPTH_W-1:0] depth;

    function automatic logic [COORD_W-1:0] mag(input logic signed [COORD_W-1:0] v);
        return v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
    endfunction

    assign o_in_stall = (r_state != F_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign col_wrap   = (14'(r_col_cnt) + 14'd1 >= 14'(i_cfg.w));
    assign row_wrap   = (13'(r_row_cnt) + 13'd1 >= i_cfg.h);

    // One result bit per cycle of the digit-by-digit square root.
    assign rem_sh = {r_rem, r_rad[SUM_W-1 -: 2]};
    assign trial  = (REM_W+2)'({r_root, 2'b01});

    // Round to nearest: the remainder exceeds the root when the length is past the half.
    assign rounded = (ROOT_W+1)'(r_root) + ((ROOT_W+1)'(r_rem > REM_W'(r_root)));
    assign depth   = (rounded > (ROOT_W+1)'(DEPTH_MAX)) ? DEPTH_MAX : DEPTH_W'(rounded);

    assign o_push = (r_state == F_PUSH) && !i_full;
    assign o_push_data = '{depth: depth, col: r_col, row: r_row,
                           frame_start: r_start, frame_end: r_end};

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: if (accept) n_state = F_MUL;
            F_MUL:  n_state = F_ADD;
            F_ADD:  n_state = F_ROOT;
            F_ROOT: if (r_iter == ITER_W'(ROOT_W - 1)) n_state = F_PUSH;
            F_PUSH: if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr) begin
                r_col_cnt <= '0;
                r_row_cnt <= '0;
            end else if (accept) begin
                if (col_wrap) begin
                    r_col_cnt <= '0;
                    r_row_cnt <= row_wrap ? '0 : r_row_cnt + 1'b1;
                end else begin
                    r_col_cnt <= r_col_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_col   <= r_col_cnt;
            r_row   <= r_row_cnt;
            r_start <= (r_col_cnt == '0) && (r_row_cnt == '0);
            r_end   <= col_wrap && row_wrap;
            r_mx    <= mag(i_in_data.pos_x);
            r_my    <= mag(i_in_data.pos_y);
            r_mz    <= mag(i_in_data.pos_z);
        end
        if (r_state == F_MUL) begin
            r_sx <= r_mx * r_mx;
            r_sy <= r_my * r_my;
            r_sz <= r_mz * r_mz;
        end
        if (r_state == F_ADD) begin
            r_rad  <= SUM_W'(r_sx) + SUM_W'(r_sy) + SUM_W'(r_sz);
            r_rem  <= '0;
            r_root <= '0;
            r_iter <= '0;
        end
        if (r_state == F_ROOT) begin
            r_rad  <= r_rad << 2;
            r_iter <= r_iter + 1'b1;
            if (rem_sh >= trial) begin
                r_rem  <= REM_W'(rem_sh - trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= REM_W'(rem_sh);
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end
endmodule

FILE: hw/rtl/dmpb_queue.sv
// Two-entry queue between the front and back parts.
`timescale 1ns / 1ps
module dmpb_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  dmpb_pkg::t_q i_push_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output dmpb_pkg::t_q o_pop_data
);
    import dmpb_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);

    t_q            r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_cnt;

    assign o_full     = (r_cnt == (PW+1)'(Q_DEPTH));
    assign o_empty    = (r_cnt == '0);
    assign o_pop_data = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == PW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == PW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_push_data;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("queue read while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(Q_DEPTH)) else $error("queue count out of range");
`endif
endmodule

FILE: hw/rtl/dmpb_back.sv
// Back part: walks the 2x2 minimum cascade for one pixel and emits results.
`timescale 1ns / 1ps
module dmpb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dmpb_pkg::t_cfg i_cfg,
    input  logic           i_empty,
    input  dmpb_pkg::t_q   i_q_data,
    output logic           o_pop,
    output logic           o_out_valid,
    output dmpb_pkg::t_out o_out_data,
    input  logic           i_out_stall
);
    import dmpb_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int LW = $clog2(MAX_LEVELS);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RD   = 2'd1;
    localparam logic [1:0] B_EMIT = 2'd2;

    logic [DEPTH_W-1:0] r_store [MAX_WIDTH];
    logic [DEPTH_W-1:0] r_left  [MAX_LEVELS];

    logic [1:0]         r_state;
    logic [LVL_W-1:0]   r_lvl;
    logic [COL_W-1:0]   r_c;
    logic [ROW_W-1:0]   r_r;
    logic [DEPTH_W-1:0] r_v, r_rd, r_tf;
    logic               r_end;
    logic               r_out_valid;
    t_out               r_out;

    logic [LVL_W-1:0]   top;
    logic               can_emit, emit, tf_upd;
    logic [DEPTH_W-1:0] tf_new, pmin;
    logic [LVL_W:0]     lvl_up;
    logic [13:0]        two_nw, two_nh;
    logic               stop_lvl, stop_sz, c_even, r_even, stop_idx, done;
    logic [31:0]        idx_full;
    logic [AW-1:0]      idx;

    assign top      = i_cfg.nl - 1'b1;
    assign can_emit = !r_out_valid || !i_out_stall;
    assign emit     = (r_state == B_EMIT) && can_emit;
    assign o_pop    = (r_state == B_IDLE) && !i_empty;

    assign tf_upd = (r_lvl == top) && (r_r == '0) && (r_c <= COL_W'(1));
    assign tf_new = tf_upd ? min24(r_tf, r_v) : r_tf;

    assign lvl_up   = (LVL_W+1)'(r_lvl) + 1'b1;
    assign two_nw   = 14'(i_cfg.w >> lvl_up) << 1;
    assign two_nh   = 14'(i_cfg.h >> lvl_up) << 1;
    assign stop_lvl = (lvl_up >= (LVL_W+1)'(i_cfg.nl));
    assign stop_sz  = (14'(r_c) >= two_nw) || (14'(r_r) >= two_nh);
    assign c_even   = !r_c[0];
    assign r_even   = !r_r[0];
    assign pmin     = min24(r_left[r_lvl[LW-1:0]], r_v);

    // Each level's row of pair minima sits after those of the finer levels.
    assign idx_full = 32'(MAX_WIDTH) - (32'(MAX_WIDTH) >> r_lvl) + 32'(r_c >> 1);
    assign idx      = idx_full[AW-1:0];
    assign stop_idx = (idx_full >= 32'(MAX_WIDTH));
    assign done     = stop_lvl || stop_sz || c_even || stop_idx || r_even;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_tf        <= DEPTH_MAX;
        end else begin
            if (emit) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_state <= B_RD;
                        if (i_q_data.frame_start) r_tf <= DEPTH_MAX;
                    end
                end
                B_RD: r_state <= B_EMIT;
                B_EMIT: begin
                    if (emit) begin
                        r_tf    <= tf_new;
                        r_state <= done ? B_IDLE : B_RD;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_lvl <= '0;
            r_c   <= i_q_data.col;
            r_r   <= i_q_data.row;
            r_v   <= i_q_data.depth;
            r_end <= i_q_data.frame_end;
        end
        if (r_state == B_RD) r_rd <= r_store[idx];
        if (emit) begin
            r_out.level           <= r_lvl;
            r_out.col             <= 12'(r_c);
            r_out.row             <= r_r;
            r_out.depth           <= r_v;
            r_out.last            <= done;
            r_out.frame_min_valid <= done && r_end;
            r_out.frame_min       <= (done && r_end) ? tf_new : '0;
            if (!stop_lvl && !stop_sz && c_even) r_left[r_lvl[LW-1:0]] <= r_v;
            if (!stop_lvl && !stop_sz && !c_even && !stop_idx && r_even)
                r_store[idx] <= pmin;
            if (!done) begin
                r_v   <= min24(r_rd, pmin);
                r_c   <= r_c >> 1;
                r_r   <= r_r >> 1;
                r_lvl <= r_lvl + 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_rd_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_RD |=> r_state == B_EMIT) else $error("read not followed by emit");
    a_emit_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_EMIT |-> $past(r_state) == B_RD || $past(r_state) == B_EMIT)
        else $error("emit without a store read");
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != B_IDLE |-> r_lvl < i_cfg.nl) else $error("level beyond the top");
`endif
endmodule

FILE: hw/rtl/depth_min_pyramid_builder.sv
// Top level: configuration registers, front, queue and back of the pyramid builder.
// Each item passes the front's multiply, add, square-root and push states, the
// queue, and the back's read and emit states; level 0 is emitted first, then each
// coarser level it completes. The front takes a new item only after its push.
// Reset (synchronous, active low) clears counters, queue and handshakes; the
// pair-minimum memory needs no clearing pass.
`timescale 1ns / 1ps
module depth_min_pyramid_builder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  dmpb_pkg::t_in   i_in_data,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output dmpb_pkg::t_out  o_out_data,
    input  logic            i_out_stall,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import dmpb_pkg::*;

    logic [12:0]      r_image_width, r_image_height;
    logic [LVL_W-1:0] r_level_count;
    logic             wr, cfg_wr;
    logic [1:0]       reg_idx;
    t_cfg             cfg;
    logic             push, full, pop, empty;
    t_q               push_data, pop_data;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = wr && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT ||
                            reg_idx == REG_LEVELS);

    always_comb begin
        case (reg_idx)
            REG_WIDTH:  prdata = 32'(r_image_width);
            REG_HEIGHT: prdata = 32'(r_image_height);
            REG_LEVELS: prdata = 32'(r_level_count);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= 13'd4096;
            r_image_height <= 13'd2048;
            r_level_count  <= 4'd12;
        end else if (wr) begin
            case (reg_idx)
                REG_WIDTH:  r_image_width  <= pwdata[12:0];
                REG_HEIGHT: r_image_height <= pwdata[12:0];
                REG_LEVELS: r_level_count  <= pwdata[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.w = (r_image_width == '0) ? 13'd1 :
                (32'(r_image_width) > 32'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : r_image_width;
        cfg.h = (r_image_height == '0) ? 13'd1 :
                (r_image_height > MAX_HEIGHT) ? MAX_HEIGHT : r_image_height;
        cfg.nl = (r_level_count == '0) ? LVL_W'(1) :
                 (32'(r_level_count) > 32'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS) : r_level_count;
    end

    dmpb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg), .i_cfg_wr(cfg_wr),
        .i_in_valid(i_in_valid), .i_in_data(i_in_data), .o_in_stall(o_in_stall),
        .o_push(push), .o_push_data(push_data), .i_full(full)
    );

    dmpb_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_push_data(push_data),
        .o_full(full), .i_pop(pop), .o_empty(empty), .o_pop_data(pop_data)
    );

    dmpb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg), .i_empty(empty),
        .i_q_data(pop_data), .o_pop(pop), .o_out_valid(o_out_valid),
        .o_out_data(o_out_data), .i_out_stall(i_out_stall)
    );
endmodule

FILE: tb/depth_min_pyramid_checker.sv
// Checker for the pyramid builder: predicts every result and compares it with the output.
`timescale 1ns / 1ps
module depth_min_pyramid_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  dmpb_pkg::t_in     i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  dmpb_pkg::t_out    i_out_data,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [3:0]        i_paddr,
    input  logic [31:0]       i_pwdata,
    output int                o_fail_count,
    output int                o_pending
);
    import dmpb_pkg::*;

    localparam int PIX_MAX_W  = 4096;
    localparam int PIX_MAX_H  = 4096;
    localparam int LEVELS_MAX = 12;

    logic [12:0] cfg_width;
    logic [12:0] cfg_height;
    logic [3:0]  cfg_levels;
    int unsigned pair_min[PIX_MAX_W];
    int unsigned left_min[LEVELS_MAX];
    int unsigned cur_col;
    int unsigned cur_row;
    int unsigned top_min;
    t_out        pending_results[$];

    assign o_pending = pending_results.size();

    function automatic longint unsigned magnitude(input logic signed [COORD_W-1:0] v);
        longint signed s;
        s = v;
        return (s < 0) ? longint'(-s) : longint'(s);
    endfunction

    // Rounded Euclidean length in Q12.12, saturated to the depth width.
    function automatic int unsigned path_length(input t_in p);
        longint unsigned ax, ay, az, sum, rem, root, bitv;
        ax = magnitude(p.pos_x);
        ay = magnitude(p.pos_y);
        az = magnitude(p.pos_z);
        sum = ax * ax + ay * ay + az * az;
        rem = sum;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        if (sum - root * root > root) root++;
        return (root > 64'hFFFFFF) ? 32'hFFFFFF : int'(root);
    endfunction

    function automatic int unsigned lesser(input int unsigned a, input int unsigned b);
        return (a < b) ? a : b;
    endfunction

    task automatic predict_pyramid(input t_in p);
        int unsigned w, h, nl, top, v, c, r, lvl, nw, nh, pm, idx;
        bit          frame_end;
        t_out        res;
        t_out        batch[$];
        w  = cfg_width;
        h  = cfg_height;
        nl = cfg_levels;
        if (w < 1) w = 1;
        if (w > PIX_MAX_W) w = PIX_MAX_W;
        if (h < 1) h = 1;
        if (h > PIX_MAX_H) h = PIX_MAX_H;
        if (nl < 1) nl = 1;
        if (nl > LEVELS_MAX) nl = LEVELS_MAX;
        top = nl - 1;
        if (cur_col >= w) cur_col = 0;
        if (cur_row >= h) cur_row = 0;
        if (cur_col == 0 && cur_row == 0) top_min = 32'hFFFFFF;
        v = path_length(p);
        c = cur_col;
        r = cur_row;
        lvl = 0;
        forever begin
            res = '0;
            res.level = lvl[3:0];
            res.col   = c[11:0];
            res.row   = r[11:0];
            res.depth = v[23:0];
            batch = {batch, res};
            if (lvl == top && r == 0 && c <= 1) top_min = lesser(top_min, v);
            if (lvl + 1 >= nl) break;
            nw = w >> (lvl + 1);
            nh = h >> (lvl + 1);
            if (c >= 2 * nw || r >= 2 * nh) break;
            if (c[0] == 1'b0) begin
                left_min[lvl] = v;
                break;
            end
            pm  = lesser(left_min[lvl], v);
            idx = (PIX_MAX_W - (PIX_MAX_W >> lvl)) + (c >> 1);
            if (idx >= PIX_MAX_W) break;
            if (r[0] == 1'b0) begin
                pair_min[idx] = pm;
                break;
            end
            v = lesser(pair_min[idx], pm);
            c >>= 1;
            r >>= 1;
            lvl++;
        end
        frame_end = (cur_col == w - 1) && (cur_row == h - 1);
        batch[$].last = 1'b1;
        if (frame_end) begin
            batch[$].frame_min_valid = 1'b1;
            batch[$].frame_min       = top_min[23:0];
        end
        if (cur_col + 1 >= w) begin
            cur_col = 0;
            cur_row = (cur_row + 1 >= h) ? 0 : cur_row + 1;
        end else begin
            cur_col++;
        end
        foreach (batch[i]) pending_results = {pending_results, batch[i]};
    endtask

    task automatic compare_result(input t_out got);
        t_out want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            o_fail_count++;
            return;
        end
        want = pending_results.pop_front();
        if (got.level !== want.level || got.col !== want.col || got.row !== want.row
                || got.depth !== want.depth || got.last !== want.last
                || got.frame_min_valid !== want.frame_min_valid
                || got.frame_min !== want.frame_min) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_width  <= 13'd4096;
            cfg_height <= 13'd2048;
            cfg_levels <= 4'd12;
            cur_col = 0;
            cur_row = 0;
            top_min = 32'hFFFFFF;
            o_fail_count = 0;
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) compare_result(i_out_data);
            if (i_in_valid && !i_in_stall) predict_pyramid(i_in_data);
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_WIDTH: begin
                        cfg_width <= i_pwdata[12:0];
                    end
                    REG_HEIGHT: begin
                        cfg_height <= i_pwdata[12:0];
                    end
                    REG_LEVELS: begin
                        cfg_levels <= i_pwdata[3:0];
                    end
                    default: begin
                    end
                endcase
                if (i_paddr[3:2] == REG_WIDTH || i_paddr[3:2] == REG_HEIGHT
                        || i_paddr[3:2] == REG_LEVELS) begin
                    cur_col = 0;
                    cur_row = 0;
                end
            end
        end
    end
endmodule

FILE: tb/depth_min_pyramid_builder_tb.sv
// Testbench top for the pyramid builder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module depth_min_pyramid_builder_tb;
    import dmpb_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 410;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    t_in         in_data;
    logic        in_stall;
    logic        out_valid;
    t_out        out_data;
    logic        out_stall;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          send_gap_pct = 0;
    int          stall_pct = 0;
    int          sent;

    depth_min_pyramid_builder DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_data(in_data), .o_in_stall(in_stall),
        .o_out_valid(out_valid), .o_out_data(out_data), .i_out_stall(out_stall),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    depth_min_pyramid_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        out_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
        if (cycles >= CYCLE_LIMIT) begin
            $display("depth_min_pyramid_builder regression: fail");
            $finish;
        end
    end

    // The idle pattern follows how far the random part has progressed.
    always @(sent) begin
        if (sent < RANDOM_ITEMS / 3) begin
            send_gap_pct = 37;
            stall_pct    = 79;
        end else if (sent < 2 * RANDOM_ITEMS / 3) begin
            send_gap_pct = 79;
            stall_pct    = 37;
        end else begin
            send_gap_pct = 0;
            stall_pct    = 0;
        end
    end

    task automatic send_pixel(input t_in p);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do @(posedge i_clk); while (in_stall);
        sent++;
    endtask

    // Waits for the output to drain, then lets any work still in flight settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_geometry(input int w, input int h, input int nl);
        wait_idle();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_LEVELS, nl);
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(5))
            0: return 24'sh800000;
            1: return 24'sh7FFFFF;
            2: return COORD_W'(int'($urandom_range(4095)) - 2048);
            3: return COORD_W'($urandom_range(65535));
            default: return COORD_W'($urandom);
        endcase
    endfunction

    initial begin
        t_in p;
        int  w, h, nl, n, pick;
        sent         = 0;
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // One 4x4 frame of three levels; the top level has no entry (0,1).
        set_geometry(4, 4, 3);
        for (int i = 0; i < 16; i++) begin
            case (i % 4)
                0: p = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF};
                1: p = '{24'sh800000, 24'sh800000, 24'sh800000};
                2: p = '{24'sh000000, 24'sh000000, 24'sh000000};
                default: p = '{COORD_W'(24'sh001000 * i), -24'sh000800, 24'sh000003};
            endcase
            send_pixel(p);
        end
        // A 5x3 frame drops its odd column and row; a 2x1 frame hits both top entries.
        set_geometry(5, 3, 2);
        for (int i = 0; i < 15; i++) send_pixel('{rand_coord(), rand_coord(), rand_coord()});
        set_geometry(2, 1, 1);
        repeat (2) send_pixel('{rand_coord(), rand_coord(), rand_coord()});

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(9);
            case (pick)
                0: begin
                    w = 0; h = 0; nl = 0; n = 6;
                end
                1: begin
                    w = 8191; h = 8191; nl = 15; n = 20;
                end
                2: begin
                    w = 4096; h = 2; nl = 12; n = 24;
                end
                3: begin
                    w = 2; h = 4096; nl = 1; n = 12;
                end
                default: begin
                    w  = $urandom_range(9, 2);
                    h  = $urandom_range(6, 1);
                    nl = $urandom_range(5);
                    n  = w * h * $urandom_range(2, 1) + $urandom_range(3);
                end
            endcase
            set_geometry(w, h, nl);
            for (int i = 0; i < n; i++) send_pixel('{rand_coord(), rand_coord(), rand_coord()});
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("depth_min_pyramid_builder regression: pass");
        end else begin
            $display("depth_min_pyramid_builder regression: fail");
        end
        $finish;
    end
endmodule

FILE: filelist.f
hw/rtl/dmpb_pkg.sv
hw/rtl/dmpb_front.sv
hw/rtl/dmpb_queue.sv
hw/rtl/dmpb_back.sv
hw/rtl/depth_min_pyramid_builder.sv
tb/depth_min_pyramid_checker.sv
tb/depth_min_pyramid_builder_tb.sv
